// File: rtl/ptob_pkg.sv
// Shared types, codes and helpers for the price-time order book.
// Used by ptob_slot_ram, ptob_scan and price_time_order_book.
`default_nettype none
package ptob_pkg;

  localparam int PTOB_ORDER_SLOTS    = 256;
  localparam int PTOB_SNAPSHOT_LEVELS = 32;

  localparam int IN_W  = 136;
  localparam int OUT_W = 240;

  localparam logic [30:0] QMAX = 31'h7FFF_FFFF;

  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_CANCEL  = 3'd1;
  localparam logic [2:0] CMD_CONSUME = 3'd2;
  localparam logic [2:0] CMD_FIND    = 3'd3;
  localparam logic [2:0] CMD_SNAP    = 3'd4;
  localparam logic [2:0] CMD_TOTALS  = 3'd5;

  localparam logic [2:0] OC_DONE      = 3'd0;
  localparam logic [2:0] OC_DUP       = 3'd1;
  localparam logic [2:0] OC_FULL      = 3'd2;
  localparam logic [2:0] OC_NOT_FOUND = 3'd3;
  localparam logic [2:0] OC_EMPTY     = 3'd4;
  localparam logic [2:0] OC_PARTIAL   = 3'd5;
  localparam logic [2:0] OC_FILLED    = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD_GO,
    ST_CMD_SCAN,
    ST_APPLY,
    ST_BEST_GO,
    ST_BEST_SCAN,
    ST_SIDE_START,
    ST_LVL_GO,
    ST_LVL_SCAN,
    ST_LVL_NEXT,
    ST_SIDE_END,
    ST_CONT,
    ST_PUSH,
    ST_NEXT_SIDE,
    ST_FINISH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic        side;
    logic [31:0] price;
    logic [30:0] remaining;
    logic [30:0] filled;
    logic        partial;
    logic [31:0] arrival;
  } rec_t;

  typedef struct packed {
    logic        sd;
    logic        has_prev;
    logic [31:0] prev;
    logic [31:0] key;
    logic [31:0] arr_now;
  } scan_ctl_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic        side;
    logic [31:0] ref_id;
    logic [31:0] price;
    logic [30:0] qty;
    logic [30:0] filled;
    logic [12:0] cnt;
  } item_t;

  // bid side: higher is better; ask side: lower is better
  function automatic logic better(logic sd, logic [31:0] a, logic [31:0] b);
    better = sd ? (a < b) : (a > b);
  endfunction

  function automatic item_t rec_item(logic [2:0] oc, rec_t r);
    item_t it;
    it.outcome = oc;
    it.side    = r.side;
    it.ref_id  = r.key;
    it.price   = r.price;
    it.qty     = r.remaining;
    it.filled  = r.filled;
    it.cnt     = 13'd0;
    rec_item   = it;
  endfunction

  function automatic item_t key_item(logic [2:0] oc, logic sd, logic [31:0] key);
    item_t it;
    it         = '0;
    it.outcome = oc;
    it.side    = sd;
    it.ref_id  = key;
    key_item   = it;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ptob_slot_ram.sv
// Order slot memory with registered read, plus per-slot valid flags.
// Depends on ptob_pkg for the slot record type.
`default_nettype none
module ptob_slot_ram
  import ptob_pkg::*;
#(
  parameter int SLOTS = PTOB_ORDER_SLOTS,
  parameter int IW    = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          we,
  input  wire logic          vwe,
  input  wire logic          vval,
  input  wire logic [IW-1:0] waddr,
  input  wire rec_t          wdata,
  input  wire logic [IW-1:0] raddr,
  output rec_t               rdata,
  output logic               rvalid
);

  rec_t           mem [SLOTS];
  logic [SLOTS-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rvalid <= 1'b0;
    end else begin
      if (vwe) begin
        valid[waddr] <= vval;
      end
      rvalid <= valid[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ptob_scan.sv
// Shared scan unit: walks all slots, one per cycle, and tracks key match,
// first free slot, front order / next level of a side, level sum, best prices.
// Depends on ptob_pkg and drives the read port of ptob_slot_ram.
`default_nettype none
module ptob_scan
  import ptob_pkg::*;
#(
  parameter int SLOTS = PTOB_ORDER_SLOTS,
  parameter int IW    = 8,
  parameter int SW    = 39
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire scan_ctl_t     ctl,
  output logic [IW-1:0]      rd_addr,
  input  wire rec_t          rd_rec,
  input  wire logic          rd_valid,
  output logic               done,
  output logic               match_found,
  output logic [IW-1:0]      match_idx,
  output rec_t               match_rec,
  output logic               free_found,
  output logic [IW-1:0]      free_idx,
  output logic               best_got,
  output logic [IW-1:0]      best_idx,
  output rec_t               best_rec,
  output logic [SW-1:0]      lvl_sum,
  output logic [IW:0]        lvl_cnt,
  output logic [31:0]        bid_best,
  output logic [31:0]        ask_best
);

  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic [IW-1:0] cnt;
  logic          issuing;
  logic          dv;
  logic [IW-1:0] d_idx;
  logic [31:0]   best_age;
  logic          bid_got, ask_got;

  logic [31:0] age_i;
  logic        on_side, take_new, same;

  assign rd_addr = cnt;
  assign done    = dv && (d_idx == LAST_IDX);

  always_comb begin
    age_i    = ctl.arr_now - rd_rec.arrival;
    on_side  = rd_valid && (rd_rec.side == ctl.sd) &&
               (!ctl.has_prev || better(ctl.sd, ctl.prev, rd_rec.price));
    take_new = on_side && (!best_got || better(ctl.sd, rd_rec.price, best_rec.price));
    same     = on_side && !take_new && (rd_rec.price == best_rec.price);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      dv      <= 1'b0;
      cnt     <= '0;
    end else begin
      dv <= issuing;
      if (start) begin
        issuing <= 1'b1;
        cnt     <= '0;
      end else if (issuing) begin
        if (cnt == LAST_IDX) begin
          issuing <= 1'b0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    d_idx <= cnt;
    if (start) begin
      match_found <= 1'b0;
      free_found  <= 1'b0;
      best_got    <= 1'b0;
      bid_got     <= 1'b0;
      ask_got     <= 1'b0;
      bid_best    <= '0;
      ask_best    <= '0;
      lvl_sum     <= '0;
      lvl_cnt     <= '0;
    end else if (dv) begin
      if (rd_valid && !match_found && rd_rec.key == ctl.key) begin
        match_found <= 1'b1;
        match_idx   <= d_idx;
        match_rec   <= rd_rec;
      end
      if (!rd_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= d_idx;
      end
      if (take_new) begin
        best_got <= 1'b1;
        best_idx <= d_idx;
        best_rec <= rd_rec;
        best_age <= age_i;
        lvl_sum  <= SW'(rd_rec.remaining);
        lvl_cnt  <= (IW+1)'(1);
      end else if (same) begin
        lvl_sum <= lvl_sum + SW'(rd_rec.remaining);
        lvl_cnt <= lvl_cnt + 1'b1;
        // older order at the same price moves to the front
        if (age_i > best_age) begin
          best_idx <= d_idx;
          best_rec <= rd_rec;
          best_age <= age_i;
        end
      end
      if (rd_valid && !rd_rec.side && (!bid_got || rd_rec.price > bid_best)) begin
        bid_got  <= 1'b1;
        bid_best <= rd_rec.price;
      end
      if (rd_valid && rd_rec.side && (!ask_got || rd_rec.price < ask_best)) begin
        ask_got  <= 1'b1;
        ask_best <= rd_rec.price;
      end
    end
  end

  a_done_ends_scan: assert property (@(posedge clk) disable iff (rst)
    done |-> !issuing)
    else $error("scan done while reads still issued");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start |=> !best_got && !match_found && !free_found)
    else $error("scan results not cleared at start");

  a_dv_follows: assert property (@(posedge clk) disable iff (rst)
    issuing |=> dv)
    else $error("read data valid lost");

endmodule
`default_nettype wire

// File: rtl/price_time_order_book.sv
// Price-time order book. Every scan walks all ORDER_SLOTS slots, one per cycle
// through the slot memory read port. Add, cancel, consume and find: two scans;
// the result item is offered after the second scan, and the next command is
// accepted only after that item is taken. Snapshot and totals: one scan, then
// one per level found plus one per side (a snapshot skips it when the depth is
// reached). Sync reset clears valid flags, counters.
`default_nettype none
module price_time_order_book
  import ptob_pkg::*;
#(
  parameter int ORDER_SLOTS     = PTOB_ORDER_SLOTS,
  parameter int SNAPSHOT_LEVELS = PTOB_SNAPSHOT_LEVELS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // order_key, side, price_ticks, quantity, filled_amount, snapshot_depth
  input  wire logic [IN_W-1:0]  s_tdata,
  // command
  input  wire logic [2:0]       s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // item_side, order_ref, level_price, qty_value, filled_value, count_value,
  // top bid price, top ask price, sequence_res
  output logic [OUT_W-1:0]      m_tdata,
  // outcome
  output logic [2:0]            m_tuser,
  output logic                  m_tlast
);

  localparam int IW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int SW = 31 + IW;
  localparam logic [5:0] SNAP_MAX = 6'(SNAPSHOT_LEVELS);

  state_t state, state_next;

  logic [2:0]  cmd_r;
  logic [31:0] key_r, price_r;
  logic [30:0] qty_r, filled_r;
  logic [5:0]  depth_r, k;
  logic        side_i, has, side_fin;
  logic [31:0] prev;
  logic [SW-1:0] tot;
  logic [12:0] lvls;
  item_t       pend, nxt, new_item, apply_item;
  logic        pend_valid;
  logic [31:0] bb_r, ba_r, arr_cnt, chg;

  // scan and memory wiring
  scan_ctl_t     ctl;
  logic          scan_start, scan_done;
  logic [IW-1:0] rd_addr;
  rec_t          rd_rec;
  logic          rd_valid;
  logic          match_found, free_found, best_got;
  logic [IW-1:0] match_idx, free_idx, best_idx;
  rec_t          match_rec, best_rec;
  logic [SW-1:0] lvl_sum;
  logic [IW:0]   lvl_cnt;
  logic [31:0]   bid_best, ask_best;

  logic          we, vwe, vval, inc_arr, inc_chg;
  logic [IW-1:0] waddr;
  rec_t          wdata;

  logic [5:0]  in_depth;
  logic [30:0] lvl_sat, tot_sat;
  logic [31:0] fill_sum;

  assign in_depth = s_tdata[132:127];
  assign lvl_sat  = (lvl_sum > SW'(QMAX)) ? QMAX : lvl_sum[30:0];
  assign tot_sat  = (tot > SW'(QMAX)) ? QMAX : tot[30:0];
  assign fill_sum = {1'b0, best_rec.filled} + {1'b0, qty_r};

  assign ctl.sd       = side_i;
  assign ctl.has_prev = has;
  assign ctl.prev     = prev;
  assign ctl.key      = key_r;
  assign ctl.arr_now  = arr_cnt;

  ptob_slot_ram #(.SLOTS(ORDER_SLOTS), .IW(IW)) u_ram (
    .clk    (clk),
    .rst    (rst),
    .we     (we),
    .vwe    (vwe),
    .vval   (vval),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr  (rd_addr),
    .rdata  (rd_rec),
    .rvalid (rd_valid)
  );

  ptob_scan #(.SLOTS(ORDER_SLOTS), .IW(IW), .SW(SW)) u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .ctl         (ctl),
    .rd_addr     (rd_addr),
    .rd_rec      (rd_rec),
    .rd_valid    (rd_valid),
    .done        (scan_done),
    .match_found (match_found),
    .match_idx   (match_idx),
    .match_rec   (match_rec),
    .free_found  (free_found),
    .free_idx    (free_idx),
    .best_got    (best_got),
    .best_idx    (best_idx),
    .best_rec    (best_rec),
    .lvl_sum     (lvl_sum),
    .lvl_cnt     (lvl_cnt),
    .bid_best    (bid_best),
    .ask_best    (ask_best)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == CMD_SNAP || s_tuser == CMD_TOTALS) begin
            state_next = ST_BEST_GO;
          end else if (s_tuser <= CMD_FIND) begin
            state_next = ST_CMD_GO;
          end
        end
      end
      ST_CMD_GO:    state_next = ST_CMD_SCAN;
      ST_CMD_SCAN:  if (scan_done) state_next = ST_APPLY;
      ST_APPLY:     state_next = ST_BEST_GO;
      ST_BEST_GO:   state_next = ST_BEST_SCAN;
      ST_BEST_SCAN: begin
        if (scan_done) begin
          state_next = (cmd_r == CMD_SNAP || cmd_r == CMD_TOTALS) ? ST_SIDE_START : ST_EMIT;
        end
      end
      ST_SIDE_START: begin
        state_next = (cmd_r == CMD_SNAP && depth_r == 6'd0) ? ST_SIDE_END : ST_LVL_GO;
      end
      ST_LVL_GO:   state_next = ST_LVL_SCAN;
      ST_LVL_SCAN: if (scan_done) state_next = ST_LVL_NEXT;
      ST_LVL_NEXT: begin
        if (!best_got) begin
          state_next = ST_SIDE_END;
        end else if (cmd_r == CMD_SNAP) begin
          state_next = pend_valid ? ST_PUSH : ST_CONT;
        end else begin
          state_next = ST_LVL_GO;
        end
      end
      ST_SIDE_END: begin
        if (cmd_r == CMD_TOTALS && !side_fin) begin
          state_next = pend_valid ? ST_PUSH : ST_CONT;
        end else begin
          state_next = ST_NEXT_SIDE;
        end
      end
      ST_CONT: begin
        if (side_fin) begin
          state_next = ST_NEXT_SIDE;
        end else if (k == depth_r) begin
          state_next = ST_SIDE_END;
        end else begin
          state_next = ST_LVL_GO;
        end
      end
      ST_PUSH:      if (m_tready) state_next = ST_CONT;
      ST_NEXT_SIDE: state_next = side_i ? ST_FINISH : ST_SIDE_START;
      ST_FINISH:    state_next = ST_EMIT;
      ST_EMIT:      if (m_tready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // outputs and command decisions
  always_comb begin
    s_tready   = (state == ST_IDLE);
    m_tvalid   = (state == ST_PUSH) || (state == ST_EMIT);
    m_tlast    = (state == ST_EMIT);
    scan_start = (state == ST_CMD_GO) || (state == ST_BEST_GO) || (state == ST_LVL_GO);

    we         = 1'b0;
    vwe        = 1'b0;
    vval       = 1'b0;
    waddr      = free_idx;
    wdata      = best_rec;
    inc_arr    = 1'b0;
    inc_chg    = 1'b0;
    apply_item = key_item(OC_NOT_FOUND, 1'b0, key_r);

    unique case (cmd_r)
      CMD_ADD: begin
        if (match_found) begin
          apply_item = key_item(OC_DUP, side_i, key_r);
        end else if (!free_found) begin
          apply_item = key_item(OC_FULL, side_i, key_r);
        end else begin
          apply_item      = key_item(OC_DONE, side_i, key_r);
          we              = 1'b1;
          vwe             = 1'b1;
          vval            = 1'b1;
          waddr           = free_idx;
          wdata.key       = key_r;
          wdata.side      = side_i;
          wdata.price     = price_r;
          wdata.remaining = qty_r;
          wdata.filled    = filled_r;
          wdata.partial   = 1'b0;
          wdata.arrival   = arr_cnt;
          inc_arr         = 1'b1;
          inc_chg         = 1'b1;
        end
      end
      CMD_CANCEL: begin
        if (match_found) begin
          apply_item = rec_item(OC_DONE, match_rec);
          vwe        = 1'b1;
          waddr      = match_idx;
          inc_chg    = 1'b1;
        end
      end
      CMD_CONSUME: begin
        waddr = best_idx;
        if (!best_got) begin
          apply_item = key_item(OC_EMPTY, side_i, 32'd0);
        end else if (qty_r >= best_rec.remaining) begin
          apply_item = rec_item(OC_FILLED, best_rec);
          vwe        = 1'b1;
          inc_chg    = 1'b1;
        end else begin
          apply_item      = rec_item(OC_PARTIAL, best_rec);
          we              = 1'b1;
          wdata.remaining = best_rec.remaining - qty_r;
          wdata.filled    = fill_sum[31] ? QMAX : fill_sum[30:0];
          wdata.partial   = 1'b1;
          inc_chg         = 1'b1;
        end
      end
      CMD_FIND: begin
        if (match_found) begin
          apply_item = rec_item(OC_DONE, match_rec);
        end
      end
      default: ;
    endcase

    if (state != ST_APPLY) begin
      we      = 1'b0;
      vwe     = 1'b0;
      inc_arr = 1'b0;
      inc_chg = 1'b0;
    end

    new_item         = '0;
    new_item.outcome = OC_DONE;
    new_item.side    = side_i;
    if (state == ST_LVL_NEXT) begin
      new_item.price = best_rec.price;
      new_item.qty   = lvl_sat;
      new_item.cnt   = 13'(lvl_cnt);
    end else begin
      new_item.qty   = tot_sat;
      new_item.cnt   = lvls;
    end

    m_tuser = pend.outcome;
    m_tdata = {4'd0, chg, ba_r, bb_r, pend.cnt, pend.filled, pend.qty,
               pend.price, pend.ref_id, pend.side};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      arr_cnt    <= '0;
      chg        <= '0;
    end else begin
      state <= state_next;
      if (inc_arr) arr_cnt <= arr_cnt + 32'd1;
      if (inc_chg) chg <= chg + 32'd1;
      if (state == ST_BEST_SCAN && scan_done) begin
        pend_valid <= 1'b0;
      end
      if ((state == ST_LVL_NEXT && best_got && cmd_r == CMD_SNAP) ||
          (state == ST_SIDE_END && cmd_r == CMD_TOTALS && !side_fin)) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cmd_r    <= s_tuser;
        key_r    <= s_tdata[31:0];
        side_i   <= s_tdata[32];
        price_r  <= s_tdata[64:33];
        qty_r    <= s_tdata[95:65];
        filled_r <= s_tdata[126:96];
        depth_r  <= (in_depth > SNAP_MAX) ? SNAP_MAX : in_depth;
        has      <= 1'b0;
      end
      ST_APPLY: pend <= apply_item;
      ST_BEST_SCAN: begin
        if (scan_done) begin
          bb_r     <= bid_best;
          ba_r     <= ask_best;
          side_i   <= (cmd_r == CMD_SNAP || cmd_r == CMD_TOTALS) ? 1'b0 : side_i;
          has      <= 1'b0;
          k        <= '0;
          tot      <= '0;
          lvls     <= '0;
          side_fin <= 1'b0;
        end
      end
      ST_LVL_NEXT: begin
        if (best_got) begin
          prev <= best_rec.price;
          has  <= 1'b1;
          if (cmd_r == CMD_SNAP) begin
            k <= k + 6'd1;
            if (pend_valid) nxt <= new_item;
            else pend <= new_item;
          end else begin
            tot  <= tot + lvl_sum;
            lvls <= lvls + 13'd1;
          end
        end
      end
      ST_SIDE_END: begin
        if (cmd_r == CMD_TOTALS && !side_fin) begin
          side_fin <= 1'b1;
          if (pend_valid) nxt <= new_item;
          else pend <= new_item;
        end
      end
      ST_PUSH: if (m_tready) pend <= nxt;
      ST_NEXT_SIDE: begin
        side_i   <= 1'b1;
        has      <= 1'b0;
        k        <= '0;
        tot      <= '0;
        lvls     <= '0;
        side_fin <= 1'b0;
      end
      ST_FINISH: if (!pend_valid) pend <= '0;
      default: ;
    endcase
  end

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input ready while an item is offered");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser <= CMD_TOTALS) |=> !s_tready)
    else $error("ready again right after a command");

  a_chg_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (chg == $past(chg)) || (chg == $past(chg) + 32'd1))
    else $error("change counter jumped");

  a_push_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUSH) |-> pend_valid)
    else $error("push without a pending item");

endmodule
`default_nettype wire
